// ===== src/plp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg
// Shared widths, codes and the cell command type of the positional list engine.
// ----------------------------------------------------------------------------
package plp_pkg;

  localparam int LIST_DEPTH_DEF = 16;

  localparam int REQ_W = 2;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int IDX_W = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_UNDER  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [POS_W-1:0]        pos_m1;
    logic [POS_W-1:0]        cnt_m1;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== src/plp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_req_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface plp_req_if import plp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink (input valid, input req_type, input position, input value,
                output ready);
endinterface

// ===== src/plp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_res_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface plp_res_if import plp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] value_res;
  logic [IDX_W-1:0]        index;
  logic                    last;

  modport source (output valid, output status, output value_res, output index,
                  output last, input ready);
  modport sink (input valid, input status, input value_res, input index,
                input last, output ready);
endinterface

// ===== src/plp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_cell
// One list entry; shifts toward its neighbors on insert, delete and rotate.
// ----------------------------------------------------------------------------
module plp_cell import plp_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] prev_data,
  input  logic signed [VAL_W-1:0] next_data,
  input  logic signed [VAL_W-1:0] wrap_data,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] sel_data
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic signed [VAL_W-1:0] data_next;
  logic                    hit;

  assign hit      = (cmd.pos_m1 == MY_IDX);
  assign sel_data = hit ? data : '0;

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_INSERT: begin
        if (MY_IDX > cmd.pos_m1) begin
          data_next = prev_data;
        end else if (hit) begin
          data_next = cmd.value;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= cmd.pos_m1) begin
          data_next = next_data;
        end
      end
      OP_ROTATE: begin
        if (MY_IDX < cmd.cnt_m1) begin
          data_next = next_data;
        end else if (MY_IDX == cmd.cnt_m1) begin
          data_next = wrap_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== src/positional_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed values in a row of shift cells: insert, delete, list.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | req_type, position, value
//  res     | out | valid/ready  | status, value_res, index, last
//
//  insert, delete and errors: the result is registered as the item is taken
//  listing: once the item is taken, one entry per cycle while results are taken,
//  paced by the cell row rotating its first count entries toward cell zero
//  a new item is taken only once the pending result has been taken
//  rst clears the count, control and output valid; entries need no reset
// ----------------------------------------------------------------------------
module positional_list_engine_top import plp_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  plp_req_if.sink      req,
  plp_res_if.source    res
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                    state;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        k;
  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]        out_index;
  logic                    out_last;

  logic                    out_free;
  logic                    acc;
  logic                    pos_zero;
  logic                    ins_bad;
  logic                    del_bad;
  logic                    full;
  logic                    list_step;
  logic                    list_end;
  cell_cmd_t               cmd;

  logic signed [VAL_W-1:0] cell_data [LIST_DEPTH];
  logic signed [VAL_W-1:0] cell_sel [LIST_DEPTH];
  logic signed [VAL_W-1:0] del_value;

  logic                    ld;
  logic [ST_W-1:0]         ld_status;
  logic signed [VAL_W-1:0] ld_value;
  logic [IDX_W-1:0]        ld_index;

  assign out_free  = !out_valid || res.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  assign pos_zero = (req.position == '0);
  assign ins_bad  = pos_zero ||
                    ({1'b0, req.position} > ((POS_W+1)'(cnt) + (POS_W+1)'(1)));
  assign del_bad  = pos_zero || (req.position > POS_W'(cnt));
  assign full     = (cnt == CNT_W'(LIST_DEPTH));

  assign list_step = (state == S_LIST) && out_free;
  assign list_end  = (k == cnt - CNT_W'(1));

  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.pos_m1 = req.position - POS_W'(1);
    cmd.cnt_m1 = POS_W'(cnt) - POS_W'(1);
    cmd.value  = req.value;
    if (list_step) begin
      cmd.op = OP_ROTATE;
    end else if (acc && req.req_type == REQ_INSERT && !ins_bad && !full) begin
      cmd.op = OP_INSERT;
    end else if (acc && req.req_type == REQ_DELETE && cnt != '0 && !del_bad) begin
      cmd.op = OP_DELETE;
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    plp_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .prev_data ((i == 0) ? cell_data[0] : cell_data[(i == 0) ? 0 : i - 1]),
      .next_data ((i == LIST_DEPTH - 1) ? cell_data[i]
                                        : cell_data[(i == LIST_DEPTH - 1) ? i : i + 1]),
      .wrap_data (cell_data[0]),
      .data      (cell_data[i]),
      .sel_data  (cell_sel[i])
    );
  end

  always_comb begin
    del_value = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      del_value = del_value | cell_sel[i];
    end
  end

  // result to load this cycle
  always_comb begin
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_value  = '0;
    ld_index  = '0;
    if (list_step) begin
      ld       = 1'b1;
      ld_value = cell_data[0];
      ld_index = IDX_W'(k) + IDX_W'(1);
    end else if (acc) begin
      case (req.req_type)
        REQ_INSERT: begin
          ld = 1'b1;
          if (ins_bad) begin
            ld_status = ST_BADPOS;
          end else if (full) begin
            ld_status = ST_FULL;
          end else begin
            ld_value = req.value;
            ld_index = req.position[IDX_W-1:0];
          end
        end
        REQ_DELETE: begin
          ld = 1'b1;
          if (cnt == '0) begin
            ld_status = ST_UNDER;
          end else if (del_bad) begin
            ld_status = ST_BADPOS;
          end else begin
            ld_value = del_value;
            ld_index = req.position[IDX_W-1:0];
          end
        end
        REQ_LIST: begin
          if (cnt == '0) begin
            ld        = 1'b1;
            ld_status = ST_EMPTY;
          end
        end
        default: begin
          ld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end
      if (cmd.op == OP_INSERT) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.op == OP_DELETE) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (acc && req.req_type == REQ_LIST && cnt != '0) begin
        state <= S_LIST;
        k     <= '0;
      end
      if (list_step) begin
        k <= k + CNT_W'(1);
        if (list_end) begin
          state <= S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status <= ld_status;
      out_value  <= ld_value;
      out_index  <= ld_index;
      out_last   <= !list_step || list_end;
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.value_res = out_value;
  assign res.index     = out_index;
  assign res.last      = out_last;

endmodule

// ===== src/plp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module plp_checker import plp_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic [REQ_W-1:0]        req_type,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic [ST_W-1:0]         res_status,
  input logic signed [VAL_W-1:0] res_value,
  input logic [IDX_W-1:0]        res_index,
  input logic                    res_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) &&
      $stable(res_value) && $stable(res_index) && $stable(res_last))
    else $error("result item changed while stalled");

  a_no_take_when_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !(res_valid && !res_ready))
    else $error("request taken while a result waits");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_INSERT || req_type == REQ_DELETE)
      |=> res_valid && res_last)
    else $error("insert or delete gave no final result");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      res_value == '0 && res_index == '0 && res_last)
    else $error("error result carries data");

endmodule

bind positional_list_engine_top plp_checker u_plp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_value  (res.value_res),
  .res_index  (res.index),
  .res_last   (res.last)
);

// ===== verif/positional_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top_tb
// Self-checking bench for the positional list engine. Named tests drive
// insert, delete, listing and unused requests through the request channel.
// A local copy of the list predicts every result item, and a checker matches
// each accepted result field by field in order. Both channels idle in random
// bursts, and one long result stall fills the block until it holds off input.
// ----------------------------------------------------------------------------
module positional_list_engine_top_tb;
  import plp_pkg::*;

  localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 3 * LIST_DEPTH + 10;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_res;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } list_result_t;

  logic clk;
  logic rst;

  plp_req_if req_ch ();
  plp_res_if res_ch ();

  positional_list_engine_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  list_result_t            pending_results[$];
  logic signed [VAL_W-1:0] list_model[$];
  list_result_t            oldest_result;
  int                      fail_count;
  int                      cycle_count;
  bit                      tx_idle_en;
  bit                      rx_idle_en;
  bit                      hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d value_res %0d index %0d last %0d",
               res_ch.status, res_ch.value_res, res_ch.index, res_ch.last);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_ch.status !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d", oldest_result.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.value_res !== oldest_result.value_res) begin
          $error("value_res: expected %0d, actual %0d",
                 oldest_result.value_res, res_ch.value_res);
          fail_count++;
        end
        if (res_ch.index !== oldest_result.index) begin
          $error("index: expected %0d, actual %0d", oldest_result.index, res_ch.index);
          fail_count++;
        end
        if (res_ch.last !== oldest_result.last) begin
          $error("last: expected %0d, actual %0d", oldest_result.last, res_ch.last);
          fail_count++;
        end
      end
    end
  end

  function automatic list_result_t make_result(input logic [ST_W-1:0] status,
                                               input logic signed [VAL_W-1:0] value,
                                               input int index, input bit last);
    list_result_t r;
    r.status    = status;
    r.value_res = value;
    r.index     = index[IDX_W-1:0];
    r.last      = last;
    return r;
  endfunction

  task automatic predict_request(input logic [REQ_W-1:0] kind,
                                 input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
    int cnt;
    int p;
    logic signed [VAL_W-1:0] removed;
    cnt = list_model.size();
    p = int'(pos);
    case (kind)
      REQ_INSERT: begin
        if (p == 0 || p > cnt + 1) begin
          pending_results.push_back(make_result(ST_BADPOS, '0, 0, 1'b1));
        end else if (cnt >= LIST_DEPTH) begin
          pending_results.push_back(make_result(ST_FULL, '0, 0, 1'b1));
        end else begin
          list_model.insert(p - 1, val);
          pending_results.push_back(make_result(ST_OK, val, p, 1'b1));
        end
      end
      REQ_DELETE: begin
        if (cnt == 0) begin
          pending_results.push_back(make_result(ST_UNDER, '0, 0, 1'b1));
        end else if (p == 0 || p > cnt) begin
          pending_results.push_back(make_result(ST_BADPOS, '0, 0, 1'b1));
        end else begin
          removed = list_model[p - 1];
          list_model.delete(p - 1);
          pending_results.push_back(make_result(ST_OK, removed, p, 1'b1));
        end
      end
      REQ_LIST: begin
        if (cnt == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < cnt; i++) begin
            pending_results.push_back(make_result(ST_OK, list_model[i], i + 1,
                                                  i + 1 == cnt));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // called right after a rising edge; returns at the edge that takes the item
  task automatic send_item(input logic [REQ_W-1:0] kind, input int pos,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos[POS_W-1:0];
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(kind, pos[POS_W-1:0], val);
  endtask

  task automatic test_empty_list();
    send_item(REQ_LIST, 0, 32'sd0);
    send_item(REQ_DELETE, 0, 32'sd0);
    send_item(REQ_DELETE, 255, -32'sd1);
    send_item(REQ_DELETE, 1, 32'sd0);
  endtask

  task automatic test_insert_positions();
    send_item(REQ_INSERT, 0, 32'sd5);
    send_item(REQ_INSERT, 2, 32'sd6);
    send_item(REQ_INSERT, 1, 32'sh7fffffff);
    send_item(REQ_INSERT, 2, 32'sh80000000);
    send_item(REQ_INSERT, 1, 32'sd0);
    send_item(REQ_INSERT, 255, -32'sd1);
    send_item(REQ_LIST, 0, 32'sd0);
  endtask

  task automatic test_delete_positions();
    send_item(REQ_DELETE, 0, 32'sd0);
    send_item(REQ_DELETE, list_model.size() + 1, 32'sd0);
    send_item(REQ_DELETE, list_model.size(), 32'sd0);
    send_item(REQ_DELETE, 1, 32'sd0);
    send_item(REQ_UNUSED, 1, 32'sd9);
    send_item(REQ_UNUSED, 170, -32'sd1);
    send_item(REQ_LIST, 85, 32'sd0);
  endtask

  task automatic test_full_list();
    while (list_model.size() < LIST_DEPTH) begin
      send_item(REQ_INSERT, $urandom_range(1, list_model.size() + 1), $urandom);
    end
    send_item(REQ_INSERT, LIST_DEPTH + 1, $urandom);
    send_item(REQ_INSERT, 1, $urandom);
    send_item(REQ_INSERT, LIST_DEPTH + 2, $urandom);
    send_item(REQ_DELETE, LIST_DEPTH + 1, 32'sd0);
    send_item(REQ_LIST, 0, 32'sd0);
    while (list_model.size() > 0) begin
      send_item(REQ_DELETE, $urandom_range(1, list_model.size()), $urandom);
    end
    send_item(REQ_LIST, 0, 32'sd0);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 || list_model.size() >= LIST_DEPTH) begin
        send_item(REQ_LIST, 0, 32'sd0);
      end else begin
        send_item(REQ_INSERT, list_model.size() + 1, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int sel;
    int cnt;
    int pos;
    bit grow;
    sent = 0;
    grow = 1'b1;
    while (sent < n_items) begin
      if (sent % 48 == 47) grow = ~grow;
      if (sent == n_items - QUIET_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      cnt = list_model.size();
      sel = $urandom_range(0, 99);
      if (sel < (grow ? 60 : 25)) begin
        pos = ($urandom_range(0, 99) < 85) ? $urandom_range(1, cnt + 1) : $urandom_range(0, 255);
        send_item(REQ_INSERT, pos, $urandom);
        sent++;
      end else if (sel < 80) begin
        if (cnt > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(1, cnt);
        else pos = $urandom_range(0, 255);
        send_item(REQ_DELETE, pos, $urandom);
        sent++;
      end else if (sel < 95) begin
        send_item(REQ_LIST, $urandom_range(0, 255), $urandom);
        sent++;
      end else begin
        send_item(REQ_UNUSED, $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_request = 1'b0;
    rst <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_positions();
    test_delete_positions();
    test_full_list();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      if (pending_results.size() != 0) begin
        $error("%0d result items never arrived", pending_results.size());
      end
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/plp_pkg.sv
src/plp_req_if.sv
src/plp_res_if.sv
src/plp_cell.sv
src/positional_list_engine_top.sv
src/plp_checker.sv
verif/positional_list_engine_top_tb.sv
